// ===== sv/cwfs_pkg.sv =====
// cwfs_pkg: shared types and constants for the congestion window lookup
// used by every module of congestion_window_from_sequence; no dependencies
`default_nettype none

package cwfs_pkg;

    localparam int SEQ_WIDTH_DEF = 32;

    localparam int WIN_W = 16;
    localparam int LIMIT_W = 16;
    localparam int X_W = 34;
    localparam int SQ_DIGITS_PER_STAGE = 4;
    localparam int SQ_STAGES = 5;
    localparam int SQ_DIGITS = SQ_DIGITS_PER_STAGE * SQ_STAGES;
    localparam int X_PAD_W = 2 * SQ_DIGITS;
    localparam int RT_W = SQ_DIGITS;
    localparam int RM_W = RT_W + 2;
    localparam int N_W = RT_W + 1;

    localparam logic [WIN_W-1:0] WIN_MAX = '1;
    localparam logic [WIN_W-1:0] WIN_MIN = WIN_W'(1);

    typedef enum logic [1:0] {
        REG_SLOW   = 2'd0,
        REG_FLAT   = 2'd1,
        REG_LINEAR = 2'd2
    } t_region;

    typedef struct packed {
        logic [WIN_W-1:0] win;
        t_region          region;
        logic             oor;
    } t_side;

endpackage

`default_nettype wire

// ===== sv/cwfs_front.sv =====
// cwfs_front: region decision, slow-start and flat windows, radicand build
// two register stages; depends on cwfs_pkg
`default_nettype none

module cwfs_front
    import cwfs_pkg::*;
#(
    parameter int SEQ_W = SEQ_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [31:0]        i_base_seq,
    input  wire logic [15:0]        i_start_window,
    input  wire logic [15:0]        i_slow_start_limit,
    input  wire logic [31:0]        i_query_seq,
    output logic                    o_valid,
    output t_side                   o_side,
    output logic [X_PAD_W-1:0]      o_x
);

    logic [SEQ_W-1:0]          bs;
    logic [SEQ_W-1:0]          ks;
    logic [SEQ_W-1:0]          a;
    logic [SEQ_W-1:0]          b;
    logic [SEQ_W-1:0]          ka;
    logic [SEQ_W-1:0]          kb;
    logic [SEQ_W-1:0]          kbase;
    logic signed [SEQ_W+1:0]   ss;
    t_side                     n1_side;

    logic                      r1_valid;
    t_side                     r1_side;
    logic [31:0]               r1_ttm;
    logic [SEQ_W-1:0]          r1_d;
    logic                      r2_valid;
    t_side                     r2_side;
    logic [X_W-1:0]            r2_x;

    always_comb begin
        bs    = i_base_seq[SEQ_W-1:0];
        ks    = i_query_seq[SEQ_W-1:0];
        a     = bs - SEQ_W'(i_start_window) + SEQ_W'(i_slow_start_limit);
        b     = a + SEQ_W'(i_slow_start_limit);
        ka    = ks - a;
        kb    = ks - b;
        kbase = ks - bs;
        ss    = $signed({2'b00, SEQ_W'(i_start_window)})
              + $signed({{2{kbase[SEQ_W-1]}}, kbase});
        n1_side = '{win: '0, region: REG_LINEAR, oor: 1'b0};
        if (ka[SEQ_W-1]) begin
            n1_side.region = REG_SLOW;
            if (ss < $signed((SEQ_W+2)'(1))) begin
                n1_side.win = WIN_MIN;
                n1_side.oor = 1'b1;
            end else if (ss > $signed((SEQ_W+2)'(WIN_MAX))) begin
                n1_side.win = WIN_MAX;
                n1_side.oor = 1'b1;
            end else begin
                n1_side.win = ss[WIN_W-1:0];
            end
        end else if (kb[SEQ_W-1] || kb == '0) begin
            n1_side.region = REG_FLAT;
            if (i_slow_start_limit == '0) begin
                n1_side.win = WIN_MIN;
                n1_side.oor = 1'b1;
            end else begin
                n1_side.win = i_slow_start_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    // t*(t-1) and the distance from the boundary, then the radicand t(t-1) + 2d
    always_ff @(posedge i_clk) begin
        r1_side <= n1_side;
        r1_ttm  <= 32'(i_slow_start_limit) * 32'(i_slow_start_limit)
                 - 32'(i_slow_start_limit);
        r1_d    <= ka;
        r2_side <= r1_side;
        r2_x    <= X_W'(r1_ttm) + X_W'({r1_d, 1'b0});
    end

    assign o_valid = r2_valid;
    assign o_side  = r2_side;
    assign o_x     = X_PAD_W'(r2_x);

endmodule

`default_nettype wire

// ===== sv/cwfs_sqrt_stage.sv =====
// cwfs_sqrt_stage: one registered slice of the digit-by-digit square root
// depends on cwfs_pkg
`default_nettype none

module cwfs_sqrt_stage
    import cwfs_pkg::*;
#(
    parameter int DIGITS = SQ_DIGITS_PER_STAGE
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_side              i_side,
    input  wire logic [X_PAD_W-1:0] i_x,
    input  wire logic [RM_W-1:0]    i_rem,
    input  wire logic [RT_W-1:0]    i_root,
    output logic                    o_valid,
    output t_side                   o_side,
    output logic [X_PAD_W-1:0]      o_x,
    output logic [RM_W-1:0]         o_rem,
    output logic [RT_W-1:0]         o_root
);

    logic [X_PAD_W-1:0] xs;
    logic [RM_W-1:0]    rm;
    logic [RM_W-1:0]    rm_sh;
    logic [RM_W-1:0]    trial;
    logic [RT_W-1:0]    rt;

    logic               r_valid;
    t_side              r_side;
    logic [X_PAD_W-1:0] r_x;
    logic [RM_W-1:0]    r_rem;
    logic [RT_W-1:0]    r_root;

    always_comb begin
        xs    = i_x;
        rm    = i_rem;
        rt    = i_root;
        rm_sh = '0;
        trial = '0;
        for (int j = 0; j < DIGITS; j++) begin
            rm_sh = {rm[RM_W-3:0], xs[X_PAD_W-1 -: 2]};
            xs    = xs << 2;
            trial = {rt, 2'b01};
            if (rm_sh >= trial) begin
                rm = rm_sh - trial;
                rt = {rt[RT_W-2:0], 1'b1};
            end else begin
                rm = rm_sh;
                rt = {rt[RT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        r_x    <= xs;
        r_rem  <= rm;
        r_root <= rt;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_x     = r_x;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

`default_nettype wire

// ===== sv/cwfs_back.sv =====
// cwfs_back: turns root and remainder into the linear window, saturates,
// and drives the result register; depends on cwfs_pkg
`default_nettype none

module cwfs_back
    import cwfs_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire t_side           i_side,
    input  wire logic [RM_W-1:0] i_rem,
    input  wire logic [RT_W-1:0] i_root,
    output logic                 o_valid,
    output logic [WIN_W-1:0]     o_window,
    output logic [1:0]           o_region,
    output logic                 o_out_of_range
);

    logic [N_W-1:0]   n;
    t_side            n_side;
    logic             r_valid;
    t_side            r_side;

    // smallest n with n(n-1) >= x is s+1 when rem <= s, else s+2
    always_comb begin
        if (i_rem <= RM_W'(i_root)) begin
            n = N_W'(i_root) + N_W'(1);
        end else begin
            n = N_W'(i_root) + N_W'(2);
        end
        n_side = i_side;
        if (i_side.region == REG_LINEAR) begin
            if (n > N_W'(WIN_MAX)) begin
                n_side.win = WIN_MAX;
                n_side.oor = 1'b1;
            end else begin
                n_side.win = n[WIN_W-1:0];
                n_side.oor = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= n_side;
    end

    assign o_valid        = r_valid;
    assign o_window       = r_side.win;
    assign o_region       = r_side.region;
    assign o_out_of_range = r_side.oor;

endmodule

`default_nettype wire

// ===== sv/congestion_window_from_sequence.sv =====
// Congestion window lookup over a wrapping sequence space. Fully pipelined:
// a query is taken on every cycle (busy stays low) and its result appears
// with a one-cycle o_valid strobe, in order. Each query passes through the two
// front stages, the 20-digit square root split over 5 stages of 4 digits and
// the one output stage. The receiver cannot stall; each result is on the
// ports for exactly one cycle.
// depends on cwfs_pkg, cwfs_front, cwfs_sqrt_stage, cwfs_back
`default_nettype none

module congestion_window_from_sequence
    import cwfs_pkg::*;
#(
    parameter int SEQ_WIDTH = SEQ_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_base_seq,
    input  wire logic [15:0] i_start_window,
    input  wire logic [15:0] i_slow_start_limit,
    input  wire logic [31:0] i_query_seq,
    output logic             o_valid,
    output logic [15:0]      o_window,
    output logic [1:0]       o_region,
    output logic             o_out_of_range
);

    logic               sq_valid [0:SQ_STAGES];
    t_side              sq_side  [0:SQ_STAGES];
    logic [X_PAD_W-1:0] sq_x     [0:SQ_STAGES];
    logic [RM_W-1:0]    sq_rem   [0:SQ_STAGES];
    logic [RT_W-1:0]    sq_root  [0:SQ_STAGES];
    logic               accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    cwfs_front #(
        .SEQ_W (SEQ_WIDTH)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (accept),
        .i_base_seq         (i_base_seq),
        .i_start_window     (i_start_window),
        .i_slow_start_limit (i_slow_start_limit),
        .i_query_seq        (i_query_seq),
        .o_valid            (sq_valid[0]),
        .o_side             (sq_side[0]),
        .o_x                (sq_x[0])
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
        cwfs_sqrt_stage #(
            .DIGITS (SQ_DIGITS_PER_STAGE)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_valid[g]),
            .i_side  (sq_side[g]),
            .i_x     (sq_x[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .o_valid (sq_valid[g+1]),
            .o_side  (sq_side[g+1]),
            .o_x     (sq_x[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1])
        );
    end

    cwfs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (sq_valid[SQ_STAGES]),
        .i_side         (sq_side[SQ_STAGES]),
        .i_rem          (sq_rem[SQ_STAGES]),
        .i_root         (sq_root[SQ_STAGES]),
        .o_valid        (o_valid),
        .o_window       (o_window),
        .o_region       (o_region),
        .o_out_of_range (o_out_of_range)
    );

endmodule

`default_nettype wire

// ===== verif/congestion_window_from_sequence_checker.sv =====
// Checker for congestion_window_from_sequence: watches the query and result beats,
// predicts each window from the query fields and compares the results in order.
// Depends on cwfs_pkg for the region codes and the result struct.
module congestion_window_from_sequence_checker
    import cwfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_base_seq,
    input  logic [15:0] i_start_window,
    input  logic [15:0] i_slow_start_limit,
    input  logic [31:0] i_query_seq,
    input  logic        i_valid,
    input  logic [15:0] i_window,
    input  logic [1:0]  i_region,
    input  logic        i_out_of_range,
    output int          o_pending,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    t_side window_q[$];

    function automatic logic [17:0] root_floor(input logic [63:0] x);
        logic [17:0] r;
        logic [17:0] trial;
        r = '0;
        for (int i = 17; i >= 0; i--) begin
            trial = r | (18'd1 << i);
            if (64'(trial) * 64'(trial) <= x) r = trial;
        end
        return r;
    endfunction

    function automatic t_side predict_window(input logic [31:0] base, input logic [15:0] start_win,
                                             input logic [15:0] limit, input logic [31:0] query);
        logic [31:0] a_seq;
        logic [31:0] b_seq;
        logic [31:0] k_minus_a;
        logic [31:0] k_minus_b;
        logic [31:0] k_minus_base;
        logic [63:0] x;
        logic [63:0] n;
        longint      raw;
        t_side       r;
        a_seq = base - 32'(start_win) + 32'(limit);
        b_seq = a_seq + 32'(limit);
        k_minus_a = query - a_seq;
        k_minus_b = query - b_seq;
        k_minus_base = query - base;
        // serial compare: query before a point when the 32-bit difference has its top bit set
        if (k_minus_a[31]) begin
            r.region = REG_SLOW;
            raw = longint'(start_win) + longint'($signed(k_minus_base));
        end else if (k_minus_b[31] || k_minus_b == '0) begin
            r.region = REG_FLAT;
            raw = longint'(limit);
        end else begin
            // smallest n with n(n-1) >= t(t-1) + 2d
            x = 64'(limit) * 64'(limit) - 64'(limit) + 64'(k_minus_a) * 64'd2;
            n = 64'(root_floor(x));
            if (n == 0) n = 1;
            while (n * (n - 1) < x) n++;
            while (n > 1 && (n - 1) * (n - 2) >= x) n--;
            r.region = REG_LINEAR;
            raw = longint'(n);
        end
        if (raw < 1) begin
            r.win = WIN_MIN;
            r.oor = 1'b1;
        end else if (raw > 65535) begin
            r.win = WIN_MAX;
            r.oor = 1'b1;
        end else begin
            r.win = raw[15:0];
            r.oor = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_side want;
        int    errs;
        errs = 0;
        if (!i_rst_n) begin
            window_q.delete();
        end else begin
            if (i_valid) begin
                if (window_q.size() == 0) begin
                    $error("result beat with no query waiting: window %0d", i_window);
                    errs++;
                end else begin
                    want = window_q.pop_front();
                    if (i_window !== want.win) begin
                        $error("window expected %0d got %0d", want.win, i_window);
                        errs++;
                    end
                    if (i_region !== want.region) begin
                        $error("region expected %0d got %0d", want.region, i_region);
                        errs++;
                    end
                    if (i_out_of_range !== want.oor) begin
                        $error("out_of_range expected %0d got %0d", want.oor, i_out_of_range);
                        errs++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                window_q.push_back(predict_window(i_base_seq, i_start_window,
                                                  i_slow_start_limit, i_query_seq));
            end
        end
        o_pending <= window_q.size();
        if (errs != 0) o_errors <= o_errors + errs;
    end

endmodule

// ===== verif/congestion_window_from_sequence_tb.sv =====
// Top of the congestion_window_from_sequence testbench: clock, reset and query stimulus
// in bursts with gaps; checking is left to congestion_window_from_sequence_checker.
// Depends on cwfs_pkg, the block and the checker.
module congestion_window_from_sequence_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_QUERIES = 1400;
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_base_seq;
    logic [15:0] i_start_window;
    logic [15:0] i_slow_start_limit;
    logic [31:0] i_query_seq;
    logic        o_valid;
    logic [15:0] o_window;
    logic [1:0]  o_region;
    logic        o_out_of_range;
    int          pending;
    int          errors;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    congestion_window_from_sequence dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_base_seq         (i_base_seq),
        .i_start_window     (i_start_window),
        .i_slow_start_limit (i_slow_start_limit),
        .i_query_seq        (i_query_seq),
        .o_valid            (o_valid),
        .o_window           (o_window),
        .o_region           (o_region),
        .o_out_of_range     (o_out_of_range)
    );

    congestion_window_from_sequence_checker checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_base_seq         (i_base_seq),
        .i_start_window     (i_start_window),
        .i_slow_start_limit (i_slow_start_limit),
        .i_query_seq        (i_query_seq),
        .i_valid            (o_valid),
        .i_window           (o_window),
        .i_region           (o_region),
        .i_out_of_range     (o_out_of_range),
        .o_pending          (pending),
        .o_errors           (errors)
    );

    task automatic issue(input logic [31:0] base, input logic [15:0] start_win,
                         input logic [15:0] limit, input logic [31:0] query);
        i_base_seq <= base;
        i_start_window <= start_win;
        i_slow_start_limit <= limit;
        i_query_seq <= query;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [31:0] base;
        logic [31:0] query;
        logic [31:0] a_seq;
        logic [31:0] b_seq;
        logic [15:0] start_win;
        logic [15:0] limit;
        int          mode;
        base = $urandom;
        start_win = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 300)) : 16'($urandom);
        limit = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 300)) : 16'($urandom);
        a_seq = base - 32'(start_win) + 32'(limit);
        b_seq = a_seq + 32'(limit);
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1, 2: query = a_seq - 32'($urandom_range(1, 2000));
            3:       query = a_seq - 32'($urandom_range(1, 32'h7FFF_FFFF));
            4, 5:    query = a_seq + 32'($urandom_range(0, 32'(limit)));
            6, 7:    query = b_seq + 32'($urandom_range(1, 200000));
            8:       query = b_seq + 32'($urandom_range(1, 32'h7FFF_FFFF));
            default: query = $urandom;
        endcase
        issue(base, start_win, limit, query);
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("congestion_window_from_sequence verification failed");
        $finish;
    end

    initial begin
        int sent;
        int burst;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_base_seq <= '0;
        i_start_window <= '0;
        i_slow_start_limit <= '0;
        i_query_seq <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all zero and all ones
        issue(32'h0, 16'h0, 16'h0, 32'h0);
        issue('1, '1, '1, '1);
        // slow start, its last point, flat start and end, first linear point
        issue(32'd1000, 16'd10, 16'd100, 32'd1050);
        issue(32'd1000, 16'd10, 16'd100, 32'd1089);
        idle(3);
        issue(32'd1000, 16'd10, 16'd100, 32'd1090);
        issue(32'd1000, 16'd10, 16'd100, 32'd1190);
        issue(32'd1000, 16'd10, 16'd100, 32'd1191);
        // slow start below one and above the ceiling, and one linear point
        issue(32'd1000, 16'd0, 16'd5, 32'd990);
        issue(32'd0, 16'd100, 16'd0, 32'h7FFF_FFFF);
        issue(32'd500, 16'hFFFF, 16'd0, 32'd400);
        // flat region with zero threshold
        idle(1);
        issue(32'd100, 16'd5, 16'd0, 32'd95);
        // linear growth right at and just past the ceiling, and a small linear point
        issue(32'd0, 16'd0, 16'd0, 32'd2147385345);
        issue(32'd0, 16'd0, 16'd0, 32'd2147385346);
        issue(32'd0, 16'd0, 16'd0, 32'h7FFF_FFFF);
        issue(32'd0, 16'd0, 16'hFFFF, 32'h7FFF_0000);
        issue(32'd0, 16'd1, 16'd1, 32'd5);
        // wrap around zero and the serial half point
        idle(5);
        issue(32'hFFFF_FFF0, 16'd20, 16'd40, 32'h0000_0005);
        issue(32'hFFFF_FFF0, 16'd20, 16'd40, 32'hFFFF_FFFA);
        issue(32'h0, 16'h0, 16'h0, 32'h8000_0000);
        issue(32'h8000_0000, 16'hFFFF, 16'h8000, 32'h0000_0000);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_QUERIES) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < RANDOM_QUERIES; j++) begin
                send_random();
                sent++;
                if (sent == RANDOM_QUERIES / 2) wait_drained();
            end
            if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("congestion_window_from_sequence verification clean");
        end else begin
            if (pending != 0) $error("%0d queries never got a result", pending);
            $display("congestion_window_from_sequence verification failed");
        end
        $finish;
    end

endmodule
